### rtl/mlt_pkg.sv
// ----------------------------------------------------------------------------
// mlt_pkg
// Types and codes shared by the learning table cells and the top level.
// ----------------------------------------------------------------------------
package mlt_pkg;

   localparam logic [2:0] FUNC_LEARN  = 3'd0;
   localparam logic [2:0] FUNC_LOOKUP = 3'd1;
   localparam logic [2:0] FUNC_REMOVE = 3'd2;
   localparam logic [2:0] FUNC_AGE    = 3'd3;
   localparam logic [2:0] FUNC_CLEAR  = 3'd4;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   localparam logic [31:0] AGING_LIMIT_RESET = 32'd300;

   typedef struct packed {
      logic [2:0]  func;
      logic [47:0] mac;
      logic [23:0] vni;
      logic [31:0] vtep_ip;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] found_ip;
      logic [8:0]  expired_count;
      logic [8:0]  entry_count;
   } rsp_type;

   // Operation broadcast to every cell while a token walks the chain.
   typedef struct packed {
      logic [2:0]  func;
      logic [47:0] mac;
      logic [23:0] vni;
      logic [31:0] vtep_ip;
      logic [31:0] now;
      logic [31:0] limit;
      logic        commit;
   } cmd_type;

   // Token handed from cell to cell, one cell per cycle.
   typedef struct packed {
      logic        active;
      logic        hit;
      logic [31:0] hit_ip;
      logic        free_seen;
      logic [8:0]  aged;
   } token_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FINISH
   } state_type;

endpackage

### rtl/mlt_cell.sv
// ----------------------------------------------------------------------------
// mlt_cell
// One table slot: holds an entry, applies the passing operation to it and
// forwards the updated token to the next slot.
// ----------------------------------------------------------------------------
module mlt_cell (
   input  logic               clock,
   input  logic               reset,
   input  mlt_pkg::cmd_type   cmd,
   input  mlt_pkg::token_type tok_prev,
   output mlt_pkg::token_type tok_next
);
   import mlt_pkg::*;

   logic        valid_ff, valid_in;
   logic        mark_ff, mark_in;
   logic [47:0] mac_ff, mac_in;
   logic [23:0] vni_ff, vni_in;
   logic [31:0] ip_ff, ip_in;
   logic [31:0] stamp_ff, stamp_in;
   token_type   tok_ff, tok_in;

   logic        key_match;
   logic        too_old;
   logic [31:0] age;

   assign key_match = valid_ff && !tok_prev.hit && (mac_ff == cmd.mac)
                      && (vni_ff == cmd.vni);
   assign age       = cmd.now - stamp_ff;
   assign too_old   = valid_ff && (age > cmd.limit);

   always_comb begin
      valid_in = valid_ff;
      mark_in  = mark_ff;
      mac_in   = mac_ff;
      vni_in   = vni_ff;
      ip_in    = ip_ff;
      stamp_in = stamp_ff;
      tok_in   = tok_prev;

      if (tok_prev.active) begin
         case (cmd.func)
            FUNC_LEARN: begin
               // remember whether this is the lowest free slot seen so far
               mark_in = !valid_ff && !tok_prev.free_seen;
               if (!valid_ff) begin
                  tok_in.free_seen = 1'b1;
               end
               if (key_match) begin
                  ip_in      = cmd.vtep_ip;
                  stamp_in   = cmd.now;
                  tok_in.hit = 1'b1;
               end
            end
            FUNC_LOOKUP: begin
               if (key_match) begin
                  tok_in.hit    = 1'b1;
                  tok_in.hit_ip = ip_ff;
               end
            end
            FUNC_REMOVE: begin
               if (key_match) begin
                  valid_in   = 1'b0;
                  tok_in.hit = 1'b1;
               end
            end
            FUNC_AGE: begin
               if (too_old) begin
                  valid_in    = 1'b0;
                  tok_in.aged = tok_prev.aged + 9'd1;
               end
            end
            FUNC_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      // insert a new key into the marked slot after a learn that missed
      if (cmd.commit && mark_ff) begin
         valid_in = 1'b1;
         mark_in  = 1'b0;
         mac_in   = cmd.mac;
         vni_in   = cmd.vni;
         ip_in    = cmd.vtep_ip;
         stamp_in = cmd.now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         mark_ff  <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         mark_ff  <= mark_in;
         tok_ff   <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      mac_ff   <= mac_in;
      vni_ff   <= vni_in;
      ip_ff    <= ip_in;
      stamp_ff <= stamp_in;
   end

   assign tok_next = tok_ff;

endmodule

### rtl/mac_learning_table_with_aging_top.sv
// ----------------------------------------------------------------------------
// mac_learning_table_with_aging_top
// Fully associative layer-2 learning table with aging, built as a chain of
// slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one operation per transfer (learn, lookup, remove, age, clear).
//   rsp_*  : one result per operation, in order, with the entry count.
//   csr_*  : write of the aging limit; always ready, take it while idle.
// Each operation sends a token down the row of MAX_ENTRIES cells, one cell
// per cycle; every cell applies the operation to its own slot. A learn that
// misses everywhere writes the lowest free slot, if any, in the finish step
// once the output register is free. Requests do not overlap: a new request
// transfers only after the previous result has entered the output register,
// so the token walking the chain sets the throughput.
// Reset clears all slots, the entry count and the aging limit (to 300); no
// clearing pass is needed. A stalled receiver holds the result in the
// output register; the next operation still walks the chain and waits at
// its last step until the output register frees.
// ----------------------------------------------------------------------------
module mac_learning_table_with_aging_top #(
   parameter int MAX_ENTRIES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mlt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mlt_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_data
);
   import mlt_pkg::*;

   state_type   state_ff, state_in;
   req_type     op_ff, op_in;
   logic        head_ff, head_in;
   token_type   fin_ff, fin_in;
   logic [31:0] limit_ff, limit_in;
   logic [8:0]  total_ff, total_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   cmd_type     cmd;
   token_type   head_tok;
   token_type   tail_tok;
   token_type   chain [MAX_ENTRIES + 1];
   logic        req_fire;
   logic        out_free;
   logic        finish;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign finish    = (state_ff == ST_FINISH) && out_free;

   always_comb begin
      head_tok        = '0;
      head_tok.active = head_ff;
   end

   always_comb begin
      cmd.func    = op_ff.func;
      cmd.mac     = op_ff.mac;
      cmd.vni     = op_ff.vni;
      cmd.vtep_ip = op_ff.vtep_ip;
      cmd.now     = op_ff.now;
      cmd.limit   = limit_ff;
      cmd.commit  = finish && (op_ff.func == FUNC_LEARN) && !fin_ff.hit
                    && fin_ff.free_seen;
   end

   assign chain[0] = head_tok;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      mlt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .tok_prev (chain[i]),
         .tok_next (chain[i + 1])
      );
   end

   assign tail_tok = chain[MAX_ENTRIES];

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      head_in      = 1'b0;
      fin_in       = fin_ff;
      total_in     = total_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_data;
               head_in  = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (tail_tok.active) begin
               fin_in   = tail_tok;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_in.status        = STATUS_OK;
               rsp_in.found_ip      = '0;
               rsp_in.expired_count = '0;
               case (op_ff.func)
                  FUNC_LEARN: begin
                     if (!fin_ff.hit) begin
                        if (fin_ff.free_seen) begin
                           total_in = total_ff + 9'd1;
                        end else begin
                           rsp_in.status = STATUS_FULL;
                        end
                     end
                  end
                  FUNC_LOOKUP: begin
                     if (fin_ff.hit) begin
                        rsp_in.found_ip = fin_ff.hit_ip;
                     end else begin
                        rsp_in.status = STATUS_MISS;
                     end
                  end
                  FUNC_REMOVE: begin
                     if (fin_ff.hit) begin
                        total_in = total_ff - 9'd1;
                     end else begin
                        rsp_in.status = STATUS_MISS;
                     end
                  end
                  FUNC_AGE: begin
                     rsp_in.expired_count = fin_ff.aged;
                     total_in             = total_ff - fin_ff.aged;
                  end
                  FUNC_CLEAR: begin
                     total_in = '0;
                  end
                  default: begin
                  end
               endcase
               rsp_in.entry_count = total_in;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      limit_in = limit_ff;
      if (csr_valid && csr_ready) begin
         limit_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= 1'b0;
         limit_ff     <= AGING_LIMIT_RESET;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         limit_ff     <= limit_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      fin_ff <= fin_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // no token may reach the end of the chain while the controller sits idle
   a_idle_chain_empty : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !tail_tok.active)
      else $error("token reached chain end while idle");

   // an insert never overlaps a walking token
   a_commit_quiet : assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!tail_tok.active && !head_ff))
      else $error("insert issued while a token is walking");

   // a request transfer always launches a token and enters the walk state
   a_launch : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (head_ff && (state_ff == ST_WALK)))
      else $error("request transfer did not launch a token");

endmodule
